// ----- rtl/core/bdlp_pkg.sv -----
// Package for the button debounce and long-press block.
// Holds the state record, result codes, register indexes and saturating add.
// No dependencies.
package bdlp_pkg;

    localparam int unsigned TIMER_W = 32;
    localparam int unsigned DT_W    = 16;
    localparam int unsigned DEB_W   = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};

    localparam logic [DEB_W-1:0]   DEBOUNCE_RESET = 16'd50;
    localparam logic [TIMER_W-1:0] HOLD_RESET     = 32'd3000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE_TIME      = 2'd0,
        CFG_SHUTDOWN_HOLD_TIME = 2'd1
    } cfg_index_t;

    typedef enum logic [1:0] {
        ACT_NONE     = 2'd0,
        ACT_SHUTDOWN = 2'd1,
        ACT_SHORT    = 2'd2
    } action_t;

    typedef struct packed {
        logic               candidate_level;
        logic [TIMER_W-1:0] candidate_time;
        logic               stable_level;
        logic [TIMER_W-1:0] held_time;
        logic               shutdown_latch;
    } btn_state_t;

    // Add a sample interval to a timer, stop at the all-ones value.
    function automatic logic [TIMER_W-1:0] sat_add(input logic [TIMER_W-1:0] a,
                                                   input logic [DT_W-1:0]    b);
        logic [TIMER_W:0] sum;
        sum = {1'b0, a} + {{(TIMER_W+1-DT_W){1'b0}}, b};
        return sum[TIMER_W] ? TIMER_MAX : sum[TIMER_W-1:0];
    endfunction

endpackage

// ----- rtl/core/bdlp_step.sv -----
// One-sample update of the debounce and hold-time state.
// Purely combinational; uses bdlp_pkg for the state record and codes.
module bdlp_step (
    input  bdlp_pkg::btn_state_t            cur,
    input  logic                            raw_level,
    input  logic [bdlp_pkg::DT_W-1:0]       elapsed_time,
    input  logic [bdlp_pkg::DEB_W-1:0]      debounce_time,
    input  logic [bdlp_pkg::TIMER_W-1:0]    shutdown_hold_time,
    output bdlp_pkg::btn_state_t            nxt,
    output bdlp_pkg::action_t               action
);
    import bdlp_pkg::*;

    logic               cand_time;
    logic [TIMER_W-1:0] cand_time_next;
    logic               changed;
    logic               short_press;
    logic               latch_mid;
    logic               stable_next;
    logic [TIMER_W-1:0] held_next;

    assign cand_time = (raw_level != cur.candidate_level);

    always_comb
    begin
        // restart the candidate timer on a level change, else accumulate
        cand_time_next = cand_time ? {{(TIMER_W-DT_W){1'b0}}, elapsed_time}
                                   : sat_add(cur.candidate_time, elapsed_time);
        changed = (raw_level != cur.stable_level) &&
                  (cand_time_next >= {{(TIMER_W-DEB_W){1'b0}}, debounce_time});
        stable_next = changed ? raw_level : cur.stable_level;
        short_press = changed && !raw_level && !cur.shutdown_latch;
        latch_mid   = (changed && !raw_level) ? 1'b0 : cur.shutdown_latch;

        if (changed)
            held_next = '0;
        else if (stable_next)
            held_next = sat_add(cur.held_time, elapsed_time);
        else
            held_next = cur.held_time;

        nxt.candidate_level = raw_level;
        nxt.candidate_time  = cand_time_next;
        nxt.stable_level    = stable_next;
        nxt.held_time       = held_next;
        nxt.shutdown_latch  = latch_mid;
        action              = ACT_NONE;

        priority if (elapsed_time == '0)
        begin
            // empty interval: hold everything
            nxt    = cur;
            action = ACT_NONE;
        end
        else if (stable_next && !latch_mid && (held_next >= shutdown_hold_time))
        begin
            nxt.shutdown_latch = 1'b1;
            action             = ACT_SHUTDOWN;
        end
        else if (short_press)
        begin
            action = ACT_SHORT;
        end
        else
        begin
            action = ACT_NONE;
        end
    end

endmodule

// ----- rtl/core/button_debounce_long_press.sv -----
// Button debounce with long-press shutdown detect.
// Stages: a sample is captured in the input register (stage 1), its result in
// the result register (stage 2); a stalled result also holds stage 1.
// Throughput: one sample per cycle unless the result stalls; the state update is
// a single registered pass (two saturating adds and compares) between the stages.
// Reset: asynchronous, active low; timers, levels and latch clear, registers
// return to debounce 50 ms and shutdown hold 3000 ms.
module button_debounce_long_press (
    input  logic                              clk,
    input  logic                              rst_n,
    // sample channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              raw_level,
    input  logic [bdlp_pkg::DT_W-1:0]         elapsed_time,
    // result channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        action,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bdlp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bdlp_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import bdlp_pkg::*;

    // Configuration registers
    logic [DEB_W-1:0]   debounce_reg;
    logic [TIMER_W-1:0] hold_reg;

    // Input register (stage 1)
    logic               in_valid_reg;
    logic               raw_reg;
    logic [DT_W-1:0]    dt_reg;

    // Button state and result register (stage 2)
    btn_state_t         state_reg;
    btn_state_t         state_next;
    action_t            action_next;
    logic               out_valid_reg;
    action_t            action_reg;

    logic               fire;
    logic               in_take;

    // The config port never pushes back.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RESET;
            hold_reg     <= HOLD_RESET;
        end
        else if (cfg_valid)
        begin
            // indexes outside the register list are dropped
            if (cfg_index == CFG_DEBOUNCE_TIME)
                debounce_reg <= cfg_data[DEB_W-1:0];
            else if (cfg_index == CFG_SHUTDOWN_HOLD_TIME)
                hold_reg <= cfg_data[TIMER_W-1:0];
        end
    end

    // Advance the stage-1 sample into the state update whenever the result
    // register is empty or is being taken in this cycle.
    assign fire     = in_valid_reg && (!out_valid_reg || !out_stall);
    // Take a new sample when stage 1 is empty or drains this cycle.
    assign in_take  = !in_valid_reg || fire;
    assign in_stall = !in_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_take)
            in_valid_reg <= in_valid;
    end

    // Sample payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take && in_valid)
        begin
            raw_reg <= raw_level;
            dt_reg  <= elapsed_time;
        end
    end

    bdlp_step u_step (
        .cur                (state_reg),
        .raw_level          (raw_reg),
        .elapsed_time       (dt_reg),
        .debounce_time      (debounce_reg),
        .shutdown_hold_time (hold_reg),
        .nxt                (state_next),
        .action             (action_next)
    );

    // Commit the state and the result together on each processed sample.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
                state_reg <= state_next;
            if (fire)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            action_reg <= action_next;
    end

    assign out_valid = out_valid_reg;
    assign action    = action_reg;

    // A shutdown report always leaves the latch set behind it.
    a_shutdown_latched: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && action_reg == ACT_SHUTDOWN) |-> state_reg.shutdown_latch)
        else $error("shutdown reported without latch set");

    // A short press is reported only on a debounced release.
    a_short_released: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && action_reg == ACT_SHORT) |-> !state_reg.stable_level)
        else $error("short press reported while stable level pressed");

    // Hold time only accumulates while pressed.
    a_held_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !state_reg.stable_level |-> (state_reg.held_time == '0))
        else $error("hold time nonzero while released");

    // The shutdown latch is only set while the button is pressed.
    a_latch_pressed: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.shutdown_latch |-> state_reg.stable_level)
        else $error("shutdown latch set while released");

endmodule

// ----- tb/sv/button_debounce_long_press_test.sv -----
// Testbench for the button debounce / long-press block: drives samples and
// register writes, predicts each action in a scoreboard class and checks it.
// Depends on bdlp_pkg and button_debounce_long_press.
`timescale 1ns / 100ps

module button_debounce_long_press_test;
    import bdlp_pkg::*;

    // Percent of cycles in which either side idles, when idling is enabled.
    localparam int unsigned IDLE_PCT        = 22;
    // Receiver hold-off used to back the block up into its input.
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    // Cycles without any transfer before the run is declared hung.
    localparam int unsigned WATCHDOG_LIMIT  = 5000;
    // Cycles to watch the outputs after the last result.
    localparam int unsigned TAIL_CYCLES     = 8;
    // Samples per random phase; six phases give roughly a thousand samples.
    localparam int unsigned PHASE_SAMPLES   = 162;
    localparam int unsigned NUM_PHASES      = 6;
    localparam int unsigned MAX_PRINTED     = 40;

    // Scoreboard: own copy of the registers and debounce state, plus the queue
    // of actions still owed by the block.
    class action_ledger;
        logic [DEB_W-1:0]   deb_limit;
        logic [TIMER_W-1:0] hold_ms;
        btn_state_t         st;
        action_t            pending_actions[$];
        int unsigned        mismatches;
        int unsigned        tally[3];

        function new();
            deb_limit   = DEBOUNCE_RESET;
            hold_ms     = HOLD_RESET;
            st          = '0;
            mismatches  = 0;
            foreach (tally[i]) tally[i] = 0;
        endfunction

        function void set_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_DEBOUNCE_TIME:      deb_limit   = data[DEB_W-1:0];
                CFG_SHUTDOWN_HOLD_TIME: hold_ms     = data[TIMER_W-1:0];
                default: ;
            endcase
        endfunction

        // Timer add that pins at all ones instead of wrapping.
        function logic [TIMER_W-1:0] clamp_add(logic [TIMER_W-1:0] a,
                                               logic [DT_W-1:0] b);
            logic [TIMER_W:0] s;
            s = (TIMER_W+1)'(a) + (TIMER_W+1)'(b);
            return (s > (TIMER_W+1)'(TIMER_MAX)) ? TIMER_MAX : s[TIMER_W-1:0];
        endfunction

        // Advance the state by one accepted sample and queue its action.
        function void note_sample(logic raw, logic [DT_W-1:0] dt);
            bit      moved;
            bit      short_release;
            action_t act;
            moved         = 1'b0;
            short_release = 1'b0;
            act           = ACT_NONE;
            if (dt != '0)
            begin
                if (raw != st.candidate_level)
                begin
                    st.candidate_level = raw;
                    st.candidate_time  = TIMER_W'(dt);
                end
                else
                    st.candidate_time = clamp_add(st.candidate_time, dt);

                if (st.candidate_level != st.stable_level &&
                    st.candidate_time >= TIMER_W'(deb_limit))
                begin
                    st.stable_level = st.candidate_level;
                    moved = 1'b1;
                    if (!st.stable_level)
                    begin
                        short_release     = !st.shutdown_latch;
                        st.shutdown_latch = 1'b0;
                    end
                    st.held_time = '0;
                end

                if (st.stable_level && !moved)
                    st.held_time = clamp_add(st.held_time, dt);

                if (st.stable_level && !st.shutdown_latch && st.held_time >= hold_ms)
                begin
                    st.shutdown_latch = 1'b1;
                    act = ACT_SHUTDOWN;
                end
                else if (short_release)
                    act = ACT_SHORT;
            end
            pending_actions.push_back(act);
            tally[act]++;
        endfunction

        function int unsigned outstanding();
            return pending_actions.size();
        endfunction

        task report(string msg);
            if (mismatches < MAX_PRINTED)
                $display("%0t mismatch: %s", $time, msg);
            mismatches++;
        endtask

        // Compare one transferred result against the oldest queued action.
        task check_action(logic [1:0] got);
            action_t want;
            if (pending_actions.size() == 0)
            begin
                report($sformatf("action %0d arrived with nothing outstanding", got));
                return;
            end
            want = pending_actions.pop_front();
            if (got !== want)
                report($sformatf("action got %0d, want %0d (%s)", got, want, want.name()));
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic                  raw_level;
    logic [DT_W-1:0]       elapsed_time;
    logic                  out_valid;
    logic                  out_stall;
    logic [1:0]            action;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    action_ledger ledger = new;

    // steady: both sides stop idling. hold_req: ask the receiver for a hold-off.
    bit          steady;
    bit          hold_req;
    int unsigned samples_sent;
    int unsigned cfg_writes;

    button_debounce_long_press DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .raw_level    (raw_level),
        .elapsed_time (elapsed_time),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .action       (action),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Receiver: check every result transfer, then pick the next stall value.
    // A requested hold-off keeps stall high for a counted stretch so the block
    // fills up and pushes back on its input.
    initial
    begin
        int unsigned hold_left;
        hold_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                ledger.check_action(action);
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_OFF_CYCLES;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Watchdog: any transfer on any channel counts as progress.
    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no transfer for %0d cycles, %0d actions outstanding",
                 WATCHDOG_LIMIT, ledger.outstanding());
        $display("[button_debounce_long_press] ERROR");
        $finish;
    end

    // Offer one sample, idling at random first, and hold it until transferred.
    // Valid stays high on return so back-to-back samples need no gap.
    task automatic send_sample(input logic raw, input logic [DT_W-1:0] dt);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid     <= 1'b0;
            raw_level    <= 1'($urandom);
            elapsed_time <= DT_W'($urandom);
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        raw_level    <= raw;
        elapsed_time <= dt;
        do @(posedge clk); while (in_stall);
        ledger.note_sample(raw, dt);
        samples_sent++;
    endtask

    // Drop valid and wait until every queued action has come back.
    task automatic drain();
        in_valid <= 1'b0;
        while (ledger.outstanding() != 0)
            @(posedge clk);
    endtask

    // Leaves cfg_valid high; the caller drops it after the last write.
    task automatic write_one(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        ledger.set_reg(idx, data);
        cfg_writes++;
    endtask

    // Only call while the block is idle.
    task automatic write_regs(input logic [DEB_W-1:0] deb, input logic [TIMER_W-1:0] hold);
        write_one(CFG_DEBOUNCE_TIME, CFG_DATA_W'(deb));
        write_one(CFG_SHUTDOWN_HOLD_TIME, hold);
        cfg_valid <= 1'b0;
    endtask

    // Interval draw with an occasional ignored (zero) sample mixed in.
    function automatic logic [DT_W-1:0] pick_dt(int unsigned span);
        if ($urandom_range(15) == 0)
            return '0;
        return DT_W'($urandom_range(span, 1));
    endfunction

    // Interval scale for a steady level: big enough that presses sometimes
    // reach the shutdown hold time within a few dozen samples.
    function automatic int unsigned dwell_span();
        longint unsigned s;
        s = ledger.hold_ms / 8;
        if (s < ledger.deb_limit)
            s = ledger.deb_limit;
        if (s > 65535)
            s = 65535;
        if (s == 0)
            s = 1;
        return int'(s);
    endfunction

    // Mostly whole press/release episodes with contact bounce around each edge;
    // about one in ten bursts is pure noise over the full field ranges.
    task automatic random_phase(input int unsigned quota);
        int unsigned start;
        int unsigned bounce_span;
        logic        lvl;
        start = samples_sent;
        while (samples_sent - start < quota)
        begin
            if ($urandom_range(9) == 0)
            begin
                repeat ($urandom_range(5, 1))
                    send_sample(1'($urandom), ($urandom_range(3) == 0) ? '0 : DT_W'($urandom));
            end
            else
            begin
                bounce_span = (ledger.deb_limit > 1) ? ledger.deb_limit - 1 : 1;
                lvl = 1'b1;
                repeat (2)
                begin
                    repeat ($urandom_range(3))
                    begin
                        send_sample(lvl, pick_dt(bounce_span));
                        send_sample(!lvl, pick_dt(bounce_span));
                    end
                    repeat ($urandom_range(lvl ? 20 : 6, 1))
                        send_sample(lvl, pick_dt(dwell_span()));
                    lvl = !lvl;
                end
            end
        end
    endtask

    initial
    begin
        logic [DEB_W-1:0]   deb_set[NUM_PHASES];
        logic [TIMER_W-1:0] hold_set[NUM_PHASES];

        steady       = 1'b0;
        hold_req     = 1'b0;
        samples_sent = 0;
        cfg_writes   = 0;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        raw_level    <= 1'b0;
        elapsed_time <= '0;
        cfg_valid    <= 1'b0;
        cfg_index    <= CFG_DEBOUNCE_TIME;
        cfg_data     <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed, reset registers (50 ms debounce, 3000 ms hold).
        send_sample(1'b1, 16'd0);       // ignored sample
        send_sample(1'b1, 16'd1);       // new candidate
        send_sample(1'b0, 16'hFFFF);    // bounce back, max interval, no change vs stable
        send_sample(1'b1, 16'd49);      // candidate restarts, just short of debounce
        send_sample(1'b1, 16'd1);       // exactly the debounce time: now pressed
        send_sample(1'b1, 16'hFFFF);    // past hold time: shutdown
        send_sample(1'b1, 16'hFFFF);    // latched, no repeat
        send_sample(1'b0, 16'hFFFF);    // release after shutdown: no short press
        send_sample(1'b1, 16'd50);      // press
        send_sample(1'b1, 16'd100);
        send_sample(1'b0, 16'd50);      // release before hold: short press
        send_sample(1'b0, 16'd0);
        drain();

        // Smallest registers: edge taken on the first sample, shutdown on the next.
        write_regs(16'd1, 32'd1);
        send_sample(1'b1, 16'd1);
        send_sample(1'b1, 16'd1);
        send_sample(1'b0, 16'd1);
        send_sample(1'b1, 16'd1);
        send_sample(1'b0, 16'd1);
        drain();

        // Largest registers: debounce needs the full interval range.
        write_regs(16'hFFFF, TIMER_MAX);
        send_sample(1'b1, 16'hFFFF);
        send_sample(1'b0, 16'hFFFE);
        send_sample(1'b0, 16'd1);
        drain();

        // Random phases over several register settings, the extremes included.
        deb_set  = '{16'd50, 16'd1, 16'hFFFF, 16'd0, 16'd0, 16'd0};
        hold_set = '{32'd3000, 32'd1, TIMER_MAX, 32'd0, 32'd0, 32'd0};
        for (int p = 3; p < NUM_PHASES; p++)
        begin
            deb_set[p]  = DEB_W'($urandom_range(200, 1));
            hold_set[p] = TIMER_W'($urandom_range(5000, 1));
        end
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_regs(deb_set[p], hold_set[p]);
            if (p == 1)
                hold_req = 1'b1;        // back the block up while samples keep coming
            steady = (p == 3);          // one phase with no idling on either side
            random_phase(PHASE_SAMPLES);
            steady = 1'b0;
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d samples with bounce, noise and ignored intervals, %0d register writes",
                 samples_sent, cfg_writes);
        $display("actions seen: %0d shutdown, %0d short press, %0d none; %0d mismatches",
                 ledger.tally[ACT_SHUTDOWN], ledger.tally[ACT_SHORT],
                 ledger.tally[ACT_NONE], ledger.mismatches);
        if (ledger.mismatches == 0 && ledger.outstanding() == 0)
            $display("[button_debounce_long_press] OK");
        else
            $display("[button_debounce_long_press] ERROR");
        $finish;
    end

endmodule
